// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the ordered list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ole_pkg.sv =====
// Package with types and constants of the ordered list engine.
`default_nettype none

package ole_pkg;

	localparam int CAPACITY    = 16;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int DATA_W      = 32;
	localparam int MODE_W      = 4;
	localparam int STAT_W      = 2;
	localparam int POS_W       = 4;
	localparam int OCC_W       = 5;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 48;

	typedef enum logic [MODE_W-1:0] {
		MODE_INS_HEAD  = 4'd0,
		MODE_INS_TAIL  = 4'd1,
		MODE_INS_SORT  = 4'd2,
		MODE_RM_HEAD   = 4'd3,
		MODE_RM_TAIL   = 4'd4,
		MODE_RM_KEY    = 4'd5,
		MODE_SEARCH    = 4'd6,
		MODE_INS_AFTER = 4'd7,
		MODE_CLEAR     = 4'd8
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic {
		CS_IDLE = 1'b0,
		CS_EXEC = 1'b1
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_op;
		logic commit;
	} ctl_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ole_datapath.sv =====
// Datapath: operand registers, shift array of cells, entry count and result register.
`default_nettype none
`include "assert_macros.svh"

module ole_datapath
	import ole_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire ctl_cmd_t                 cmd,
	input  wire logic [MODE_W-1:0]        in_mode,
	input  wire logic signed [DATA_W-1:0] in_value,
	input  wire logic signed [DATA_W-1:0] in_key,
	output logic [OUT_TDATA_W-1:0]        out_data
);

	mode_t                     op_mode_q;
	logic signed [DATA_W-1:0]  op_value_q;
	logic signed [DATA_W-1:0]  op_key_q;
	logic signed [DATA_W-1:0]  cells_q [CAPACITY];
	logic signed [DATA_W-1:0]  cells_nxt [CAPACITY];
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_nxt;
	logic [OUT_TDATA_W-1:0]    out_q;

	logic [CAPACITY-1:0] eq_vec;
	logic [CAPACITY-1:0] ge_vec;
	logic [IDX_W-1:0]    key_idx;
	logic                key_found;
	logic [IDX_W-1:0]    sort_idx;
	logic                full;
	logic                empty;
	logic                ins_en;
	logic                rm_en;
	logic                clr_en;
	logic [IDX_W-1:0]    at_idx;
	logic [DATA_W-1:0]   res_value;
	status_t             res_status;
	logic [POS_W-1:0]    res_pos;

	// Capture the operands of a new transfer
	always_ff @(posedge clk) begin
		if (cmd.load_op) begin
			op_mode_q  <= mode_t'(in_mode);
			op_value_q <= in_value;
			op_key_q   <= in_key;
		end
	end

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	// Compare every live cell against key and value in parallel
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			eq_vec[i] = (CNT_W'(i) < count_q) && (cells_q[i] == op_key_q);
			ge_vec[i] = (CNT_W'(i) < count_q) && !(cells_q[i] < op_value_q);
		end
	end

	// Pick the first matching cell from the head
	always_comb begin
		key_idx   = '0;
		key_found = 1'b0;
		sort_idx  = IDX_W'(count_q);
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (eq_vec[i]) begin
				key_idx   = IDX_W'(i);
				key_found = 1'b1;
			end
			if (ge_vec[i]) begin
				sort_idx = IDX_W'(i);
			end
		end
	end

	// Decode the operation into an insert, a removal, a search or a clear, with its status
	always_comb begin
		ins_en     = 1'b0;
		rm_en      = 1'b0;
		clr_en     = 1'b0;
		at_idx     = '0;
		res_value  = '0;
		res_status = STAT_OK;
		res_pos    = '0;
		unique case (op_mode_q)
			MODE_INS_HEAD: begin
				if (full) res_status = STAT_FULL;
				else ins_en = 1'b1;
			end
			MODE_INS_TAIL: begin
				if (full) res_status = STAT_FULL;
				else begin
					ins_en = 1'b1;
					at_idx = IDX_W'(count_q);
				end
			end
			MODE_INS_SORT: begin
				if (full) res_status = STAT_FULL;
				else begin
					ins_en = 1'b1;
					at_idx = sort_idx;
				end
			end
			MODE_RM_HEAD: begin
				if (empty) res_status = STAT_EMPTY;
				else begin
					rm_en     = 1'b1;
					res_value = cells_q[0];
				end
			end
			MODE_RM_TAIL: begin
				if (empty) res_status = STAT_EMPTY;
				else begin
					rm_en     = 1'b1;
					at_idx    = IDX_W'(count_q - 1'b1);
					res_value = cells_q[at_idx];
				end
			end
			MODE_RM_KEY: begin
				if (empty) res_status = STAT_EMPTY;
				else if (!key_found) res_status = STAT_NOT_FOUND;
				else begin
					rm_en     = 1'b1;
					at_idx    = key_idx;
					res_value = cells_q[key_idx];
				end
			end
			MODE_SEARCH: begin
				if (empty) res_status = STAT_EMPTY;
				else if (!key_found) res_status = STAT_NOT_FOUND;
				else res_pos = POS_W'(key_idx);
			end
			MODE_INS_AFTER: begin
				if (empty) res_status = STAT_EMPTY;
				else if (!key_found) res_status = STAT_NOT_FOUND;
				else if (full) res_status = STAT_FULL;
				else begin
					ins_en = 1'b1;
					at_idx = key_idx + 1'b1;
				end
			end
			MODE_CLEAR: clr_en = 1'b1;
			default: ;
		endcase
	end

	// Per-cell next value: hold, take the new value, shift toward tail or head
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		always_comb begin
			cells_nxt[g] = cells_q[g];
			if (ins_en) begin
				if (IDX_W'(g) == at_idx) cells_nxt[g] = op_value_q;
				else if (g > 0) begin
					if (IDX_W'(g) > at_idx) cells_nxt[g] = cells_q[(g > 0) ? g - 1 : 0];
				end
			end else if (rm_en) begin
				if (g < CAPACITY - 1) begin
					if (IDX_W'(g) >= at_idx) begin
						cells_nxt[g] = cells_q[(g < CAPACITY - 1) ? g + 1 : g];
					end
				end
			end
		end
	end

	// Next occupancy
	always_comb begin
		priority if (clr_en) count_nxt = '0;
		else if (ins_en) count_nxt = count_q + 1'b1;
		else if (rm_en) count_nxt = count_q - 1'b1;
		else count_nxt = count_q;
	end

	// Update cells on commit
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < CAPACITY; i++) begin
				cells_q[i] <= cells_nxt[i];
			end
		end
	end

	// Update entry count on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_nxt;
		end
	end

	// Load the result register on commit
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q <= {(OUT_TDATA_W - DATA_W - STAT_W - POS_W - OCC_W)'(0),
				OCC_W'(count_nxt), res_pos, res_status, res_value};
		end
	end

	assign out_data = out_q;

	`ASSERT_NEXT(a_full_holds_count, cmd.commit && (res_status == STAT_FULL),
		$stable(count_q), "count changed on a full status")
	`ASSERT_NEXT(a_insert_grows, cmd.commit && ins_en,
		count_q == $past(count_q) + 1'b1, "insert did not grow the count")

endmodule

`default_nettype wire

// ===== hw/rtl/ole_controller.sv =====
// Controller: operation sequencing and result handshake.
`default_nettype none
`include "assert_macros.svh"

module ole_controller
	import ole_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output ctl_cmd_t  cmd
);

	ctl_state_t state_q;
	ctl_state_t state_nxt;
	logic       out_valid_q;
	logic       out_valid_nxt;

	// State and result-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			out_valid_q <= out_valid_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt     = state_q;
		cmd.load_op   = 1'b0;
		cmd.commit    = 1'b0;
		in_ready      = 1'b0;
		out_valid_nxt = out_valid_q && !out_ready;
		unique case (state_q)
			CS_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_op = in_valid;
				if (in_valid) state_nxt = CS_EXEC;
			end
			CS_EXEC: begin
				// commit once the result register is free or being drained
				if (!out_valid_q || out_ready) begin
					cmd.commit    = 1'b1;
					out_valid_nxt = 1'b1;
					state_nxt     = CS_IDLE;
				end
			end
			default: state_nxt = CS_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	`ASSERT_NOW(a_no_overwrite, cmd.commit, !out_valid_q || out_ready,
		"result overwritten before transfer")
	`ASSERT_NEXT(a_commit_frees_input, cmd.commit, in_ready && out_valid,
		"commit did not return to idle with a result")

endmodule

`default_nettype wire

// ===== hw/rtl/ordered_list_engine_top.sv =====
// Top level of the ordered list engine.
//
// Channel   Dir  Fields (tdata, low bit up)
// s_axis    in   mode[3:0], value[35:4], key[67:36], zero pad to 72
// m_axis    out  result_value[31:0], status[33:32], position[37:34],
//                occupancy[42:38], zero pad to 48
//
// Each item is accepted, then all cells are compared/shifted and the result committed.
// The engine takes no new item until the previous one has committed.
// A result sits in the output register; a new item is taken while it waits.
// A stalled result holds the commit of the next item until it transfers.
// Reset clears the entry count and control state; cells need no clearing.
`default_nettype none

module ordered_list_engine_top
	import ole_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // mode, value, key
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata   // result_value, status, position, occupancy
);

	ctl_cmd_t cmd;

	ole_controller u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	ole_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_mode  (s_tdata[MODE_W-1:0]),
		.in_value (s_tdata[MODE_W +: DATA_W]),
		.in_key   (s_tdata[MODE_W + DATA_W +: DATA_W]),
		.out_data (m_tdata)
	);

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the ordered list engine: random and directed list operations.
`timescale 1ns / 1ps
`default_nettype none

module testbench
	import ole_pkg::*;
;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int ITEM_TARGET   = 1400;
	localparam int CALM_ITEMS    = 150;
	localparam int LONG_HOLD     = 300;
	localparam int DRAIN_CYCLES  = 20;
	localparam int PAD_W         = IN_TDATA_W - MODE_W - 2 * DATA_W;
	localparam logic [DATA_W-1:0] MIN_S32 = 32'h8000_0000;
	localparam logic [DATA_W-1:0] MAX_S32 = 32'h7fff_ffff;

	// Packed so that the first output field sits in the lowest bits.
	typedef struct packed {
		logic [OCC_W-1:0]  occupancy;
		logic [POS_W-1:0]  position;
		status_t           status;
		logic [DATA_W-1:0] result_value;
	} reply_t;

	localparam int REPLY_W = $bits(reply_t);

	// List predictor and store of expected replies.
	class list_scoreboard;
		logic [DATA_W-1:0] cells [CAPACITY];
		int                fill = 0;
		reply_t            expected_replies [$];
		int                errors = 0;

		function void insert_at(int p, logic [DATA_W-1:0] v);
			for (int i = fill; i > p; i--)
				cells[i] = cells[i-1];
			cells[p] = v;
			fill++;
		endfunction

		function logic [DATA_W-1:0] take_at(int p);
			logic [DATA_W-1:0] v;
			v = cells[p];
			for (int i = p; i + 1 < fill; i++)
				cells[i] = cells[i+1];
			fill--;
			return v;
		endfunction

		// Index of the first entry equal to k, or fill when absent.
		function int find_key(logic [DATA_W-1:0] k);
			for (int i = 0; i < fill; i++)
				if (cells[i] == k)
					return i;
			return fill;
		endfunction

		// Apply one accepted operation and queue the reply it should give.
		function void predict_op(logic [MODE_W-1:0] md, logic [DATA_W-1:0] val,
				logic [DATA_W-1:0] k);
			reply_t r;
			int     idx;
			bit     full;
			bit     empty;
			r.result_value = '0;
			r.status = STAT_OK;
			r.position = '0;
			full = (fill >= CAPACITY);
			empty = (fill == 0);
			case (md)
				MODE_INS_HEAD: begin
					if (full) r.status = STAT_FULL;
					else insert_at(0, val);
				end
				MODE_INS_TAIL: begin
					if (full) r.status = STAT_FULL;
					else insert_at(fill, val);
				end
				MODE_INS_SORT: begin
					if (full) begin
						r.status = STAT_FULL;
					end else begin
						idx = 0;
						while (idx < fill && $signed(cells[idx]) < $signed(val))
							idx++;
						insert_at(idx, val);
					end
				end
				MODE_RM_HEAD: begin
					if (empty) r.status = STAT_EMPTY;
					else r.result_value = take_at(0);
				end
				MODE_RM_TAIL: begin
					if (empty) r.status = STAT_EMPTY;
					else r.result_value = take_at(fill - 1);
				end
				MODE_RM_KEY: begin
					if (empty) begin
						r.status = STAT_EMPTY;
					end else begin
						idx = find_key(k);
						if (idx >= fill) r.status = STAT_NOT_FOUND;
						else r.result_value = take_at(idx);
					end
				end
				MODE_SEARCH: begin
					if (empty) begin
						r.status = STAT_EMPTY;
					end else begin
						idx = find_key(k);
						if (idx >= fill) r.status = STAT_NOT_FOUND;
						else r.position = idx[POS_W-1:0];
					end
				end
				MODE_INS_AFTER: begin
					if (empty) begin
						r.status = STAT_EMPTY;
					end else begin
						idx = find_key(k);
						if (idx >= fill) r.status = STAT_NOT_FOUND;
						else if (full) r.status = STAT_FULL;
						else insert_at(idx + 1, val);
					end
				end
				MODE_CLEAR: fill = 0;
				default: ;
			endcase
			r.occupancy = fill[OCC_W-1:0];
			expected_replies.push_back(r);
		endfunction

		// Compare one transferred reply with the oldest expectation.
		function void check_reply(logic [OUT_TDATA_W-1:0] t);
			reply_t got;
			reply_t want;
			got = reply_t'(t[REPLY_W-1:0]);
			if (expected_replies.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected reply: value %0d status %0d pos %0d occ %0d",
						$signed(got.result_value), got.status, got.position,
						got.occupancy);
				return;
			end
			want = expected_replies.pop_front();
			if (got.result_value !== want.result_value || got.status !== want.status ||
					got.position !== want.position || got.occupancy !== want.occupancy) begin
				errors++;
				if (errors <= 10)
					$display("reply mismatch: expected value %0d status %0d pos %0d occ %0d,",
						$signed(want.result_value), want.status, want.position,
						want.occupancy,
						" got value %0d status %0d pos %0d occ %0d",
						$signed(got.result_value), got.status,
						got.position, got.occupancy);
			end
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	list_scoreboard book = new;
	bit             gaps_on = 1'b1;
	int             stalls_asked = 0;
	int             stalls_served = 0;
	int             op_items = 0;

	ordered_list_engine_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Offer one item, with an occasional idle burst ahead of it, and hold until the transfer.
	task automatic send_item(input logic [MODE_W-1:0] md, input logic [DATA_W-1:0] v,
			input logic [DATA_W-1:0] k);
		int gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{PAD_W{1'b0}}, k, v, md};
		do
			@(posedge clk);
		while (!s_tready);
		book.predict_op(md, v, k);
		if (md <= MODE_CLEAR)
			op_items++;
	endtask

	// Draw mostly from a narrow pool so keys match and duplicates pile up.
	function automatic logic [DATA_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return $urandom_range(0, 6) - 3;
		if (r < 7) begin
			case ($urandom_range(0, 3))
				0: return MIN_S32;
				1: return MAX_S32;
				2: return '0;
				default: return '1;
			endcase
		end
		return $urandom();
	endfunction

	// Pick an operation; ins_pct steers the list toward full or toward empty.
	function automatic logic [MODE_W-1:0] pick_mode(int ins_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return MODE_W'($urandom_range(MODE_CLEAR + 1, 15));
		if (r < 6)
			return MODE_CLEAR;
		if (r < 20)
			return $urandom_range(0, 1) ? MODE_SEARCH : MODE_RM_KEY;
		if ($urandom_range(0, 99) < ins_pct) begin
			case ($urandom_range(0, 3))
				0: return MODE_INS_HEAD;
				1: return MODE_INS_TAIL;
				2: return MODE_INS_SORT;
				default: return MODE_INS_AFTER;
			endcase
		end
		case ($urandom_range(0, 2))
			0: return MODE_RM_HEAD;
			1: return MODE_RM_TAIL;
			default: return MODE_RM_KEY;
		endcase
	endfunction

	// Run a stretch of random operations under one fill tendency.
	task automatic run_round(input int n);
		int                ins_pct;
		logic [MODE_W-1:0] md;
		logic [DATA_W-1:0] k;
		case ($urandom_range(0, 2))
			0: ins_pct = 80;
			1: ins_pct = 50;
			default: ins_pct = 20;
		endcase
		repeat (n) begin
			md = pick_mode(ins_pct);
			if (book.fill > 0 && $urandom_range(0, 2) != 0)
				k = book.cells[$urandom_range(0, book.fill - 1)];
			else
				k = pick_value();
			send_item(md, pick_value(), k);
		end
	endtask

	// Check each reply as it transfers and drive ready with random holds.
	initial begin : reply_sink
		int hold;
		int quiet;
		hold = 0;
		quiet = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				book.check_reply(m_tdata);
			if (stalls_served < stalls_asked) begin
				stalls_served++;
				hold = LONG_HOLD;
			end else if (hold == 0 && quiet == 0 && gaps_on) begin
				if ($urandom_range(0, 7) == 0)
					hold = $urandom_range(1, 9);
				else if ($urandom_range(0, 39) == 0)
					quiet = $urandom_range(20, 80);
			end
			if (quiet > 0)
				quiet--;
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Stop a hung run.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list: every remove, search and keyed insert reports empty.
		send_item(MODE_RM_HEAD, '0, '0);
		send_item(MODE_RM_TAIL, '0, '0);
		send_item(MODE_RM_KEY, '0, '0);
		send_item(MODE_SEARCH, '0, '0);
		send_item(MODE_INS_AFTER, 32'd1, 32'd1);
		send_item(MODE_CLEAR, '0, '0);
		// Extremes, sorted placement and equal values.
		send_item(MODE_INS_HEAD, MIN_S32, '0);
		send_item(MODE_INS_TAIL, MAX_S32, '0);
		send_item(MODE_INS_SORT, '0, '0);
		send_item(MODE_INS_SORT, '1, '0);
		send_item(MODE_INS_SORT, '0, '0);
		send_item(MODE_INS_SORT, MAX_S32, '0);
		send_item(MODE_INS_SORT, MIN_S32, '0);
		send_item(MODE_SEARCH, '0, '0);
		send_item(MODE_SEARCH, '0, 32'd5);
		send_item(MODE_INS_AFTER, 32'd7, MAX_S32);
		send_item(MODE_INS_AFTER, 32'd7, 32'd9);
		send_item(MODE_RM_KEY, '0, '0);
		send_item(MODE_RM_KEY, '0, 32'd123);
		// Unused modes leave the list alone.
		send_item(MODE_W'(MODE_CLEAR + 1), 32'h5555_aaaa, 32'haaaa_5555);
		send_item(4'hf, '1, '1);
		send_item(MODE_RM_HEAD, '0, '0);
		send_item(MODE_RM_TAIL, '0, '0);
		send_item(MODE_CLEAR, '0, '0);
		send_item(MODE_RM_TAIL, '0, '0);

		// Random rounds, with one long output stall and one full drain along the way.
		while (op_items < 450)
			run_round($urandom_range(20, 60));
		gaps_on = 1'b0;
		stalls_asked++;
		run_round(30);
		s_tvalid <= 1'b0;
		while (book.pending() != 0)
			@(posedge clk);
		gaps_on = 1'b1;
		while (op_items < ITEM_TARGET - CALM_ITEMS)
			run_round($urandom_range(20, 60));

		// Finish at full rate with no idling on either side.
		gaps_on = 1'b0;
		while (op_items < ITEM_TARGET)
			run_round($urandom_range(20, 60));
		s_tvalid <= 1'b0;

		while (book.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (book.errors == 0 && book.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ole_pkg.sv
hw/rtl/ole_datapath.sv
hw/rtl/ole_controller.sv
hw/rtl/ordered_list_engine_top.sv
bench/testbench.sv
